// File: sv/kms_pkg.sv
`default_nettype none
package kms_pkg;

    localparam int CNT_W   = 8;
    localparam int CODE_W  = 4;
    localparam int POS_W   = 2;
    localparam int LEVEL_W = 4;
    localparam int MAP_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROW0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROW1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROW2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROW3  = 3'd4;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd5;
    localparam logic [MAP_W-1:0] MAP_ROW0_RESET  = 16'hA321;
    localparam logic [MAP_W-1:0] MAP_ROW1_RESET  = 16'hB654;
    localparam logic [MAP_W-1:0] MAP_ROW2_RESET  = 16'hC987;
    localparam logic [MAP_W-1:0] MAP_ROW3_RESET  = 16'hDEF0;

    // what one column lane reports for the row being scanned
    typedef struct packed {
        logic changed;
        logic now_pressed;
        logic any_pressed;
    } t_lane_status;

endpackage
`default_nettype wire

// File: sv/kms_lane.sv
`default_nettype none
module kms_lane
    import kms_pkg::*;
#(
    parameter int ROWS  = 4,
    parameter int ROW_W = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic             i_pressed,
    input  wire logic [CNT_W-1:0] i_threshold,
    input  wire logic             i_update,
    output t_lane_status          o_status
);

    logic [CNT_W-1:0] r_count [ROWS];
    logic [ROWS-1:0]  r_stable;
    logic [CNT_W-1:0] w_cur;
    logic [CNT_W-1:0] n_count;
    logic [ROWS-1:0]  n_stable;
    logic             w_now;

    assign w_cur = r_count[i_row];

    always_comb begin
        if (i_pressed) begin
            n_count = (w_cur < i_threshold) ? w_cur + 1'b1 : w_cur;
        end else begin
            n_count = (w_cur != '0) ? w_cur - 1'b1 : w_cur;
        end
        w_now = (n_count >= i_threshold);
        n_stable = r_stable;
        n_stable[i_row] = w_now;
    end

    assign o_status.changed     = (w_now != r_stable[i_row]);
    assign o_status.now_pressed = w_now;
    assign o_status.any_pressed = |n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_count[r] <= '0;
            end
            r_stable <= '0;
        end else if (i_update) begin
            r_count[i_row] <= n_count;
            r_stable       <= n_stable;
        end
    end

endmodule
`default_nettype wire

// File: sv/kms_merge.sv
`default_nettype none
module kms_merge
    import kms_pkg::*;
#(
    parameter int COLS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_status      i_lane [COLS],
    input  wire logic [MAP_W-1:0]  i_keymap,
    input  wire logic [POS_W-1:0]  i_row,
    input  wire logic [POS_W-1:0]  i_next_row,
    input  wire logic              i_load,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_event_valid,
    output logic                   o_event_is_release,
    output logic [CODE_W-1:0]      o_key_code,
    output logic [POS_W-1:0]       o_event_row,
    output logic [POS_W-1:0]       o_event_column,
    output logic [POS_W-1:0]       o_drive_row,
    output logic                   o_any_pressed
);

    logic              r_valid;
    logic              r_ev;
    logic              r_release;
    logic [CODE_W-1:0] r_code;
    logic [POS_W-1:0]  r_ev_row;
    logic [POS_W-1:0]  r_ev_col;
    logic [POS_W-1:0]  r_drive_row;
    logic              r_any;

    logic              n_ev;
    logic              n_release;
    logic [CODE_W-1:0] n_code;
    logic [POS_W-1:0]  n_ev_row;
    logic [POS_W-1:0]  n_ev_col;
    logic              n_any;

    // lowest changing column wins, walk down so it is picked last
    always_comb begin
        n_ev      = 1'b0;
        n_release = 1'b0;
        n_code    = '0;
        n_ev_col  = '0;
        n_any     = 1'b0;
        for (int c = COLS - 1; c >= 0; c--) begin
            n_any = n_any | i_lane[c].any_pressed;
            if (i_lane[c].changed) begin
                n_ev      = 1'b1;
                n_release = ~i_lane[c].now_pressed;
                n_code    = i_keymap[CODE_W*c +: CODE_W];
                n_ev_col  = POS_W'(c);
            end
        end
        n_ev_row = n_ev ? i_row : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev        <= n_ev;
            r_release   <= n_release;
            r_code      <= n_code;
            r_ev_row    <= n_ev_row;
            r_ev_col    <= n_ev_col;
            r_drive_row <= i_next_row;
            r_any       <= n_any;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_event_valid      = r_ev;
    assign o_event_is_release = r_release;
    assign o_key_code         = r_code;
    assign o_event_row        = r_ev_row;
    assign o_event_column     = r_ev_col;
    assign o_drive_row        = r_drive_row;
    assign o_any_pressed      = r_any;

endmodule
`default_nettype wire

// File: sv/keypad_matrix_scanner_debounce.sv
`default_nettype none
// Keypad matrix scanner with per-key debounce. Each request carries the
// active-low column levels sampled while the row shown on o_drive_row of the
// previous result (row 0 after reset) was driven. One request is taken every
// clock cycle while the output register is empty or drains: one lane per column
// updates its key counter and stable state, and the merged event lands in an
// output register, so a result appears in the cycle after its request is
// taken and the input keeps flowing while that register drains. Configuration
// writes are taken in any cycle; indexes beyond the keymap rows are ignored.
module keypad_matrix_scanner_debounce
    import kms_pkg::*;
#(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [LEVEL_W-1:0]    i_column_levels,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_event_valid,
    output logic                       o_event_is_release,
    output logic [CODE_W-1:0]          o_key_code,
    output logic [POS_W-1:0]           o_event_row,
    output logic [POS_W-1:0]           o_event_column,
    output logic [POS_W-1:0]           o_drive_row,
    output logic                       o_any_pressed
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [CNT_W-1:0] r_threshold;
    logic [MAP_W-1:0] r_keymap [4];
    logic [POS_W-1:0] r_scan_row;
    logic [POS_W-1:0] n_scan_row;
    logic             w_accept;
    t_lane_status     w_lane [COLS];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = ~o_out_valid | i_out_ready;
    assign w_accept    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_keymap[0] <= MAP_ROW0_RESET;
            r_keymap[1] <= MAP_ROW1_RESET;
            r_keymap[2] <= MAP_ROW2_RESET;
            r_keymap[3] <= MAP_ROW3_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[CNT_W-1:0];
                CFG_MAP_ROW0:  r_keymap[0] <= i_cfg_data;
                CFG_MAP_ROW1:  r_keymap[1] <= i_cfg_data;
                CFG_MAP_ROW2:  r_keymap[2] <= i_cfg_data;
                CFG_MAP_ROW3:  r_keymap[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_scan_row = (r_scan_row == POS_W'(ROWS - 1)) ? '0 : r_scan_row + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
        end else if (w_accept) begin
            r_scan_row <= n_scan_row;
        end
    end

    for (genvar c = 0; c < COLS; c++) begin : g_lane
        kms_lane #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_row       (r_scan_row[ROW_W-1:0]),
            .i_pressed   (~i_column_levels[c]),
            .i_threshold (r_threshold),
            .i_update    (w_accept),
            .o_status    (w_lane[c])
        );
    end

    kms_merge #(
        .COLS (COLS)
    ) u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_lane             (w_lane),
        .i_keymap           (r_keymap[r_scan_row]),
        .i_row              (r_scan_row),
        .i_next_row         (n_scan_row),
        .i_load             (w_accept),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_event_valid      (o_event_valid),
        .o_event_is_release (o_event_is_release),
        .o_key_code         (o_key_code),
        .o_event_row        (o_event_row),
        .o_event_column     (o_event_column),
        .o_drive_row        (o_drive_row),
        .o_any_pressed      (o_any_pressed)
    );

endmodule
`default_nettype wire
